// ----- src/rmme_pkg.sv -----
// Shared types and constants for the return-map multiplier estimator.
// Used by the divider, datapath, controller, top level and checker.
package rmme_pkg;

	localparam int Q_W              = 32;
	localparam int FRAC_W           = 16;
	localparam int DIFF_W           = Q_W + 1;
	localparam int SUM_W            = 49;
	localparam int GAP_W            = 31;
	localparam int COUNT_W          = 16;
	localparam int DIV_STEPS        = 32;
	localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
	localparam int MAX_CROSSINGS_DEF = 65536;

	localparam int ADDR_W   = 2;
	localparam int APB_W    = 32;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 48;
	localparam int M_USER_W = 1;

	localparam logic [ADDR_W-1:0] REG_MIN_GAP = 2'd0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_RATIO,
		S_SHIFT,
		S_FINAL,
		S_MEAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic start_ratio;
		logic add_ratio;
		logic shift;
		logic start_mean;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic do_ratio;
		logic enough;
		logic last;
		logic div_done;
	} sts_t;

endpackage

// ----- src/rmme_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, signed saturated result.
// Depends on rmme_pkg.
module rmme_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rmme_pkg::SUM_W-1:0]       dividend,
	input  logic [rmme_pkg::DIFF_W-1:0]      divisor,
	input  logic                             neg,
	output logic                             done,
	output logic signed [rmme_pkg::Q_W-1:0]  quotient
);
	import rmme_pkg::*;

	logic [DIFF_W-1:0]    rem_q;
	logic [DIFF_W-1:0]    dsr_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic                 ovf_q;
	logic                 neg_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DIFF_W:0]  trial;
	logic             ge;
	logic [DIFF_W-1:0] rem_next;
	logic [Q_W-1:0]   lim;
	logic [Q_W-1:0]   mag;

	assign trial    = {rem_q, quo_q[DIV_STEPS-1]};
	assign ge       = trial >= {1'b0, dsr_q};
	assign rem_next = ge ? DIFF_W'(trial - {1'b0, dsr_q}) : trial[DIFF_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIFF_W'(dividend[SUM_W-1:DIV_STEPS]);
			quo_q <= dividend[DIV_STEPS-1:0];
			dsr_q <= divisor;
			neg_q <= neg;
			ovf_q <= DIFF_W'(dividend[SUM_W-1:DIV_STEPS]) >= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
	end

	// saturate: magnitude limit is 2^31 for negative, 2^31-1 for positive
	always_comb begin
		lim = neg_q ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		mag = (ovf_q || (Q_W'(quo_q) > lim)) ? lim : Q_W'(quo_q);
	end

	assign quotient = neg_q ? -$signed(mag) : $signed(mag);
	assign done     = done_q;

endmodule

// ----- src/rmme_dp.sv -----
// Datapath: crossing history, ratio sum, crossing count, divider operands and result register.
// Depends on rmme_pkg and rmme_div.
module rmme_dp #(
	parameter int MAX_CROSSINGS = rmme_pkg::MAX_CROSSINGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rmme_pkg::cmd_t                  cmd,
	output rmme_pkg::sts_t                  sts,
	input  logic [rmme_pkg::Q_W-1:0]        crossing,
	input  logic                            last_crossing,
	input  logic [rmme_pkg::GAP_W-1:0]      min_gap,
	output logic [rmme_pkg::Q_W-1:0]        mean_multiplier,
	output logic [rmme_pkg::COUNT_W-1:0]    ratio_count,
	output logic                            stable
);
	import rmme_pkg::*;

	localparam int CNT_W = $clog2(MAX_CROSSINGS + 1);

	logic signed [Q_W-1:0]   z_q;
	logic                    last_q;
	logic signed [Q_W-1:0]   prev_q;
	logic signed [Q_W-1:0]   sprev_q;
	logic [CNT_W-1:0]        items_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [Q_W-1:0]   mean_q;
	logic [COUNT_W-1:0]      count_q;
	logic                    stable_q;

	logic [DIFF_W-1:0]  num;
	logic [DIFF_W-1:0]  den;
	logic [DIFF_W-1:0]  num_mag;
	logic [DIFF_W-1:0]  den_mag;
	logic [SUM_W-1:0]   sum_mag;
	logic [CNT_W-1:0]   n;
	logic               active;
	logic               enough;
	logic               div_start;
	logic [SUM_W-1:0]   dividend;
	logic [DIFF_W-1:0]  divisor;
	logic               div_neg;
	logic               div_done;
	logic signed [Q_W-1:0] div_quot;
	logic [SUM_W:0]     acc;
	logic signed [SUM_W-1:0] acc_sat;
	logic signed [Q_W-1:0]   mean_sel;

	assign num     = {z_q[Q_W-1], z_q} - {prev_q[Q_W-1], prev_q};
	assign den     = {prev_q[Q_W-1], prev_q} - {sprev_q[Q_W-1], sprev_q};
	assign num_mag = num[DIFF_W-1] ? -num : num;
	assign den_mag = den[DIFF_W-1] ? -den : den;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign n       = items_q - CNT_W'(2);
	assign active  = items_q < CNT_W'(MAX_CROSSINGS);
	assign enough  = items_q >= CNT_W'(3);

	assign sts.do_ratio = active && (items_q >= CNT_W'(2)) && (den_mag > DIFF_W'(min_gap));
	assign sts.enough   = enough;
	assign sts.last     = last_q;
	assign sts.div_done = div_done;

	assign div_start = cmd.start_ratio | cmd.start_mean;
	assign dividend  = cmd.start_mean ? sum_mag : {num_mag, {FRAC_W{1'b0}}};
	assign divisor   = cmd.start_mean ? DIFF_W'(n) : den_mag;
	assign div_neg   = cmd.start_mean ? sum_q[SUM_W-1] : (num[DIFF_W-1] ^ den[DIFF_W-1]);

	rmme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.neg      (div_neg),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_comb begin
		acc = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-Q_W){div_quot[Q_W-1]}}, div_quot};
		if (acc[SUM_W] != acc[SUM_W-1])
			acc_sat = acc[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			acc_sat = acc[SUM_W-1:0];
		mean_sel = enough ? div_quot : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			prev_q  <= '0;
			sprev_q <= '0;
			items_q <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.capture)
				last_q <= last_crossing;
			if (cmd.add_ratio)
				sum_q <= acc_sat;
			if (cmd.shift && active) begin
				sprev_q <= prev_q;
				prev_q  <= z_q;
				items_q <= items_q + 1'b1;
			end
			if (cmd.clear) begin
				prev_q  <= '0;
				sprev_q <= '0;
				items_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			z_q <= crossing;
		if (cmd.load_out) begin
			mean_q   <= mean_sel;
			count_q  <= !enough ? '0 :
				(32'(n) > 32'd65535) ? {COUNT_W{1'b1}} : COUNT_W'(n);
			stable_q <= enough && (mean_sel > -32'sd65536) && (mean_sel < 32'sd65536);
		end
	end

	assign mean_multiplier = mean_q;
	assign ratio_count     = count_q;
	assign stable          = stable_q;

endmodule

// ----- src/rmme_ctrl.sv -----
// Controller state machine: input and output handshakes, sequencing of the datapath.
// Depends on rmme_pkg.
module rmme_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  rmme_pkg::sts_t sts,
	output rmme_pkg::cmd_t cmd
);
	import rmme_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid)
					state_d = S_EVAL;
			end
			S_EVAL: begin
				if (sts.do_ratio) begin
					cmd.start_ratio = 1'b1;
					state_d = S_RATIO;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_RATIO: begin
				if (sts.div_done) begin
					cmd.add_ratio = 1'b1;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				state_d = sts.last ? S_FINAL : S_IDLE;
			end
			S_FINAL: begin
				if (sts.enough) begin
					cmd.start_mean = 1'b1;
					state_d = S_MEAN;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_MEAN: begin
				if (sts.div_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// ----- src/return_map_multiplier_estimator.sv -----
// Return-map multiplier estimator: top level with the min_gap register and APB port.
// Depends on rmme_pkg, rmme_ctrl, rmme_dp (which holds rmme_div).

// A crossing that yields a ratio passes S_EVAL, S_RATIO and S_SHIFT between acceptance and
// readiness for the next beat, waiting in S_RATIO on the 32-step radix-2 divider shared by ratio
// and mean; a crossing with no ratio (first two of a series, denominator within min_gap, or past
// MAX_CROSSINGS) skips S_RATIO. The beat with tlast adds the mean division (skipped for a series
// shorter than three), then the result beat is loaded into the output register, waiting first
// for a previous result still held there; a new input beat is taken while it waits on m_tready.
module return_map_multiplier_estimator #(
	parameter int MAX_CROSSINGS = rmme_pkg::MAX_CROSSINGS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rmme_pkg::S_DATA_W-1:0]    s_tdata,   // [31:0] crossing
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rmme_pkg::M_DATA_W-1:0]    m_tdata,   // [31:0] mean_multiplier, [47:32] ratio_count
	output logic [rmme_pkg::M_USER_W-1:0]    m_tuser,   // [0] stable
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rmme_pkg::ADDR_W-1:0]      paddr,
	input  logic [rmme_pkg::APB_W-1:0]       pwdata,
	output logic [rmme_pkg::APB_W-1:0]       prdata,
	output logic                             pready
);
	import rmme_pkg::*;

	logic [GAP_W-1:0]   min_gap_q;
	cmd_t               cmd;
	sts_t               sts;
	logic [Q_W-1:0]     mean_multiplier;
	logic [COUNT_W-1:0] ratio_count;
	logic               stable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_gap_q <= '0;
		else if (psel && penable && pwrite && pready && paddr == REG_MIN_GAP)
			min_gap_q <= pwdata[GAP_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MIN_GAP) ? APB_W'(min_gap_q) : '0;

	rmme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmme_dp #(
		.MAX_CROSSINGS (MAX_CROSSINGS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.crossing        (s_tdata[Q_W-1:0]),
		.last_crossing   (s_tlast),
		.min_gap         (min_gap_q),
		.mean_multiplier (mean_multiplier),
		.ratio_count     (ratio_count),
		.stable          (stable)
	);

	assign m_tdata = {ratio_count, mean_multiplier};
	assign m_tuser = stable;

endmodule

// ----- src/rmme_checker.sv -----
// Port-level checks for the return-map multiplier estimator, bound to the top level.
// Depends on rmme_pkg.
module rmme_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rmme_pkg::M_DATA_W-1:0] m_tdata,
	input logic [rmme_pkg::M_USER_W-1:0] m_tuser
);
	import rmme_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat accepted while first still in work");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47:32] == 16'd0 |-> m_tdata[31:0] == 32'd0 && m_tuser[0] == 1'b0)
		else $error("short series gave nonzero mean or stable");

	a_stable_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[47:32] != 16'd0 |->
			m_tuser[0] == (m_tdata[31:16] == 16'h0000 ||
				(m_tdata[31:16] == 16'hFFFF && m_tdata[15:0] != 16'h0000)))
		else $error("stable flag disagrees with mean");

endmodule

bind return_map_multiplier_estimator rmme_checker u_rmme_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
